[rtl/core/generational_handle_table_top_defines.svh]
// ----------------------------------------------------------------------------
// Generational handle table assertion macros
// Concurrent assertion wrappers clocked on clk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_TOP_DEFINES_SVH

// checked outside reset
`define GHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define GHT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ght_pkg.sv]
// ----------------------------------------------------------------------------
// Generational handle table package
// Field widths, request/response codes, queued op and slot entry types.
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

  localparam int KIND_W   = 2;
  localparam int HANDLE_W = 31;
  localparam int SLOT_W   = 10;
  localparam int CODE_W   = 2;
  localparam int RUNS_W   = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_RUN    = 2'd3
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    CODE_OK         = 2'd0,
    CODE_NO_SLOT    = 2'd1,
    CODE_BAD_HANDLE = 2'd2
  } code_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_POP,
    BK_EXEC
  } back_state_t;

  // classified request as it sits in the queue
  typedef struct packed {
    kind_t                kind;
    logic [HANDLE_W-1:0]  handle;
    logic [HANDLE_W-1:0]  parent;
    logic [SLOT_W-1:0]    slot;
    logic                 check;
    logic                 bad_slot;
    logic                 handle_zero;
  } op_t;

  // one slot table entry; live clear means free
  typedef struct packed {
    logic                 live;
    logic [HANDLE_W-1:0]  handle;
    logic [HANDLE_W-1:0]  parent;
    logic [RUNS_W-1:0]    runs;
  } slot_word_t;

endpackage

`default_nettype wire

[rtl/core/ght_chan_if.sv]
// ----------------------------------------------------------------------------
// Generational handle table channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ght_req_if;
  logic                           valid;
  logic                           ready;
  ght_pkg::kind_t                 kind;
  logic [ght_pkg::HANDLE_W-1:0]   handle;
  logic [ght_pkg::HANDLE_W-1:0]   parent_handle;
  logic [ght_pkg::SLOT_W-1:0]     slot;
  logic                           check_permission;

  modport source (
    output valid, kind, handle, parent_handle, slot, check_permission,
    input  ready
  );
  modport sink (
    input  valid, kind, handle, parent_handle, slot, check_permission,
    output ready
  );
endinterface

interface ght_rsp_if;
  logic                           valid;
  logic                           ready;
  ght_pkg::code_t                 result_code;
  logic [ght_pkg::HANDLE_W-1:0]   handle_out;
  logic [ght_pkg::SLOT_W-1:0]     slot_out;
  logic                           slot_valid;
  logic [ght_pkg::RUNS_W-1:0]     run_count;

  modport source (
    output valid, result_code, handle_out, slot_out, slot_valid, run_count,
    input  ready
  );
  modport sink (
    input  valid, result_code, handle_out, slot_out, slot_valid, run_count,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/ght_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/ght_front.sv]
// ----------------------------------------------------------------------------
// Generational handle table front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_front #(
  parameter int NUM_SLOTS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  ght_req_if.sink       req,
  output logic          op_valid,
  output ght_pkg::op_t  op,
  input  logic          op_pop
);

  ght_pkg::op_t                  q [ght_pkg::QUEUE_DEPTH];
  ght_pkg::op_t                  cls;
  logic [ght_pkg::Q_PTR_W-1:0]   wptr;
  logic [ght_pkg::Q_PTR_W-1:0]   rptr;
  logic [ght_pkg::Q_CNT_W-1:0]   count;
  logic                          push;
  logic                          pop;

  always_comb begin
    cls.kind        = req.kind;
    cls.handle      = req.handle;
    cls.parent      = req.parent_handle;
    cls.slot        = req.slot;
    cls.check       = req.check_permission;
    cls.bad_slot    = (32'(req.slot) >= 32'(NUM_SLOTS));
    cls.handle_zero = (req.handle == '0);
  end

  assign req.ready = (count != ght_pkg::Q_CNT_W'(ght_pkg::QUEUE_DEPTH));
  assign push      = req.valid && req.ready;
  assign pop       = op_pop && op_valid;
  assign op_valid  = (count != '0);
  assign op        = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/ght_back.sv]
// ----------------------------------------------------------------------------
// Generational handle table back end
// Runs queued ops against the slot table and free stack, registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module ght_back #(
  parameter int NUM_SLOTS = 1024,
  parameter int GEN_SHIFT = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          op_valid,
  input  ght_pkg::op_t  op,
  output logic          op_pop,
  ght_rsp_if.source     rsp
);

  localparam int IW   = $clog2(NUM_SLOTS);
  localparam int FC_W = IW + 1;
  localparam int SW_W = $bits(ght_pkg::slot_word_t);
  localparam logic [31:0] GEN_INC  = 32'(1) << GEN_SHIFT;
  localparam logic [31:0] IDX_MASK = 32'(NUM_SLOTS - 1);

  ght_pkg::back_state_t state;
  ght_pkg::back_state_t state_next;

  logic [IW-1:0]                clr_cnt;
  logic [FC_W-1:0]              free_count;
  logic [IW-1:0]                current_slot;
  logic                         current_valid;
  logic [ght_pkg::HANDLE_W-1:0] cur_handle;
  ght_pkg::op_t                 op_r;
  logic [IW-1:0]                sidx;

  // memory ports
  logic                  slot_we;
  logic [IW-1:0]         slot_waddr;
  ght_pkg::slot_word_t   slot_wdata;
  logic                  slot_re;
  logic [IW-1:0]         slot_raddr;
  logic [SW_W-1:0]       slot_rbits;
  ght_pkg::slot_word_t   rd;
  logic                  stk_we;
  logic [IW-1:0]         stk_waddr;
  logic [IW-1:0]         stk_wdata;
  logic                  stk_re;
  logic [IW-1:0]         stk_raddr;
  logic [IW-1:0]         stk_rdata;

  // execute results
  logic                         out_free;
  logic                         fire;
  logic [IW-1:0]                idle_idx;
  logic [31:0]                  gen_sum;
  logic [31:0]                  gen;
  logic [ght_pkg::HANDLE_W-1:0] new_handle;
  logic                         perm_ok;
  logic                         ex_alloc;
  logic                         ex_free;
  logic                         ex_run;
  ght_pkg::slot_word_t          ex_wdata;
  ght_pkg::code_t               ex_code;
  logic [ght_pkg::HANDLE_W-1:0] ex_handle;
  logic [IW-1:0]                ex_slot;
  logic                         ex_sv;
  logic [ght_pkg::RUNS_W-1:0]   ex_runs;

  // response register
  logic                         rsp_valid;
  ght_pkg::code_t               rsp_code;
  logic [ght_pkg::HANDLE_W-1:0] rsp_handle;
  logic [ght_pkg::SLOT_W-1:0]   rsp_slot;
  logic                         rsp_sv;
  logic [ght_pkg::RUNS_W-1:0]   rsp_runs;

  ght_ram #(.WIDTH(SW_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rbits)
  );

  ght_ram #(.WIDTH(IW), .DEPTH(NUM_SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign rd       = ght_pkg::slot_word_t'(slot_rbits);
  assign out_free = !rsp_valid || rsp.ready;
  assign fire     = (state == ght_pkg::BK_EXEC) && out_free;

  always_comb begin
    case (op.kind)
      ght_pkg::KIND_LOOKUP: idle_idx = op.handle[IW-1:0];
      ght_pkg::KIND_ALLOC:  idle_idx = '0;
      default:              idle_idx = IW'(op.slot);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ght_pkg::BK_CLEAR: begin
        if (clr_cnt == IW'(NUM_SLOTS - 1)) begin
          state_next = ght_pkg::BK_IDLE;
        end
      end
      ght_pkg::BK_IDLE: begin
        if (op_valid) begin
          if (op.kind == ght_pkg::KIND_ALLOC && free_count != '0) begin
            state_next = ght_pkg::BK_POP;
          end else begin
            state_next = ght_pkg::BK_EXEC;
          end
        end
      end
      ght_pkg::BK_POP: begin
        state_next = ght_pkg::BK_EXEC;
      end
      ght_pkg::BK_EXEC: begin
        if (out_free) begin
          state_next = ght_pkg::BK_IDLE;
        end
      end
    endcase
  end

  // execute: what the op does given the slot entry read back
  always_comb begin
    gen_sum = {1'b0, rd.handle} + GEN_INC;
    gen     = gen_sum & ~IDX_MASK;
    if (gen == '0 || gen[31]) begin
      gen = GEN_INC;
    end
    new_handle = ght_pkg::HANDLE_W'(gen | 32'(sidx));
    perm_ok    = current_valid && (sidx == current_slot || rd.parent == cur_handle);

    ex_alloc  = 1'b0;
    ex_free   = 1'b0;
    ex_run    = 1'b0;
    ex_wdata  = rd;
    ex_code   = ght_pkg::CODE_OK;
    ex_handle = '0;
    ex_slot   = '0;
    ex_sv     = 1'b0;
    ex_runs   = '0;

    unique case (op_r.kind)
      ght_pkg::KIND_ALLOC: begin
        if (free_count == '0) begin
          ex_code = ght_pkg::CODE_NO_SLOT;
        end else begin
          ex_alloc        = 1'b1;
          ex_wdata.live   = 1'b1;
          ex_wdata.handle = new_handle;
          ex_wdata.parent = op_r.parent;
          ex_wdata.runs   = '0;
          ex_handle       = new_handle;
          ex_slot         = sidx;
          ex_sv           = 1'b1;
        end
      end
      ght_pkg::KIND_FREE: begin
        if (op_r.bad_slot || !rd.live || free_count == FC_W'(NUM_SLOTS)) begin
          ex_code = ght_pkg::CODE_BAD_HANDLE;
        end else begin
          ex_free       = 1'b1;
          ex_wdata.live = 1'b0;
          ex_handle     = rd.handle;
          ex_slot       = sidx;
          ex_sv         = 1'b1;
        end
      end
      ght_pkg::KIND_LOOKUP: begin
        if (op_r.handle_zero) begin
          if (current_valid) begin
            ex_handle = cur_handle;
            ex_slot   = current_slot;
            ex_sv     = 1'b1;
          end
        end else if (!rd.live || rd.handle != op_r.handle || (op_r.check && !perm_ok)) begin
          ex_code = ght_pkg::CODE_BAD_HANDLE;
        end else begin
          ex_handle = rd.handle;
          ex_slot   = sidx;
          ex_sv     = 1'b1;
        end
      end
      ght_pkg::KIND_RUN: begin
        if (op_r.bad_slot || !rd.live) begin
          ex_code = ght_pkg::CODE_BAD_HANDLE;
        end else begin
          ex_run        = 1'b1;
          ex_wdata.runs = rd.runs + 1'b1;
          ex_handle     = rd.handle;
          ex_slot       = sidx;
          ex_sv         = 1'b1;
          ex_runs       = rd.runs + 1'b1;
        end
      end
    endcase
  end

  // memory and queue controls per state
  always_comb begin
    op_pop     = 1'b0;
    slot_re    = 1'b0;
    slot_raddr = idle_idx;
    slot_we    = 1'b0;
    slot_waddr = sidx;
    slot_wdata = ex_wdata;
    stk_re     = 1'b0;
    stk_raddr  = IW'(free_count - 1'b1);
    stk_we     = 1'b0;
    stk_waddr  = IW'(free_count);
    stk_wdata  = sidx;
    unique case (state)
      ght_pkg::BK_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_cnt;
        slot_wdata = '0;
        stk_we     = 1'b1;
        stk_waddr  = clr_cnt;
        stk_wdata  = IW'(NUM_SLOTS - 1) - clr_cnt;
      end
      ght_pkg::BK_IDLE: begin
        op_pop  = op_valid;
        slot_re = op_valid;
        stk_re  = op_valid && op.kind == ght_pkg::KIND_ALLOC;
      end
      ght_pkg::BK_POP: begin
        slot_re    = 1'b1;
        slot_raddr = stk_rdata;
      end
      ght_pkg::BK_EXEC: begin
        slot_we = fire && (ex_alloc || ex_free || ex_run);
        stk_we  = fire && ex_free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ght_pkg::BK_IDLE && op_valid) begin
      op_r <= op;
      sidx <= idle_idx;
    end else if (state == ght_pkg::BK_POP) begin
      sidx <= stk_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ght_pkg::BK_CLEAR;
      clr_cnt       <= '0;
      free_count    <= FC_W'(NUM_SLOTS);
      current_slot  <= '0;
      current_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ght_pkg::BK_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (fire) begin
        if (ex_alloc) begin
          free_count <= free_count - 1'b1;
        end
        if (ex_free) begin
          free_count <= free_count + 1'b1;
        end
        if (ex_run) begin
          current_slot  <= sidx;
          current_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (ex_run) begin
        cur_handle <= rd.handle;
      end else if (ex_alloc && current_valid && sidx == current_slot) begin
        cur_handle <= new_handle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_code   <= ex_code;
      rsp_handle <= ex_handle;
      rsp_slot   <= ght_pkg::SLOT_W'(ex_slot);
      rsp_sv     <= ex_sv;
      rsp_runs   <= ex_runs;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.result_code = rsp_code;
  assign rsp.handle_out  = rsp_handle;
  assign rsp.slot_out    = rsp_slot;
  assign rsp.slot_valid  = rsp_sv;
  assign rsp.run_count   = rsp_runs;

endmodule

`default_nettype wire

[rtl/core/generational_handle_table_top.sv]
// ----------------------------------------------------------------------------
// Generational handle table
// Slot allocator handing out generation-tagged handles: alloc, free,
// lookup with optional parent check, and run with per-slot run counts.
// ----------------------------------------------------------------------------
//   port | dir | carries
//   -----+-----+-----------------------------------------------------------
//   req  | in  | kind, handle, parent_handle, slot, check_permission
//   rsp  | out | result_code, handle_out, slot_out, slot_valid, run_count
//
// In the back end free, lookup and run read the slot table, then write it
// and register the result; alloc reads the free stack first when a slot is
// free. After reset a clearing pass initializes the slot table and free
// stack; up to two requests queue meanwhile, none is executed.
// A 2-entry request queue and a result register decouple both sides.
// Slot states reduce to live/free; the running slot is always the current one.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table_top #(
  parameter int NUM_SLOTS = 1024,
  parameter int GEN_SHIFT = 12
) (
  input  logic      clk,
  input  logic      rst,
  ght_req_if.sink   req,
  ght_rsp_if.source rsp
);

  logic         op_valid;
  logic         op_pop;
  ght_pkg::op_t op;

  ght_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  ght_back #(.NUM_SLOTS(NUM_SLOTS), .GEN_SHIFT(GEN_SHIFT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

[rtl/core/ght_checker.sv]
// ----------------------------------------------------------------------------
// Generational handle table port checker
// Response channel checks, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "generational_handle_table_top_defines.svh"

module ght_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [ght_pkg::CODE_W-1:0]   result_code,
  input logic [ght_pkg::HANDLE_W-1:0] handle_out,
  input logic [ght_pkg::SLOT_W-1:0]   slot_out,
  input logic                         slot_valid,
  input logic [ght_pkg::RUNS_W-1:0]   run_count
);

  `GHT_ASSERT(a_err_names_none, rsp_valid && result_code != ght_pkg::CODE_OK |-> !slot_valid, "error response names a slot")
  `GHT_ASSERT(a_none_zero, rsp_valid && !slot_valid |-> handle_out == '0 && slot_out == '0 && run_count == '0, "response without slot carries data")
  `GHT_ASSERT(a_runs_ok, rsp_valid && run_count != '0 |-> result_code == ght_pkg::CODE_OK && slot_valid, "run count on failed response")
  `GHT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(handle_out) && $stable(result_code), "stalled response changed")
  `GHT_ASSERT_RST(a_rst_quiet, rst |=> !rsp_valid, "response valid right after reset")

endmodule

bind generational_handle_table_top ght_checker u_ght_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .result_code (rsp.result_code),
  .handle_out  (rsp.handle_out),
  .slot_out    (rsp.slot_out),
  .slot_valid  (rsp.slot_valid),
  .run_count   (rsp.run_count)
);

`default_nettype wire
